// ===== rtl/core/float_pair_snapshot_diff_classifier_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the snapshot diff classifier
// ---------------------------------------------------------------------------
`ifndef FLOAT_PAIR_SNAPSHOT_DIFF_CLASSIFIER_TOP_MACROS_SVH
`define FLOAT_PAIR_SNAPSHOT_DIFF_CLASSIFIER_TOP_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define FPSD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check an implication whose consequence lands in the next cycle.
`define FPSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/fpsd_pkg.sv =====
// ---------------------------------------------------------------------------
// fpsd_pkg
// Types, codes and helpers shared by the snapshot diff classifier.
// ---------------------------------------------------------------------------
package fpsd_pkg;

  localparam int ADDR_BITS  = 48;
  localparam int COUNT_BITS = 32;
  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_DIFF    = 3'd1,
    KIND_NEW     = 3'd2,
    KIND_GONE    = 3'd3,
    KIND_CHANGED = 3'd4
  } kind_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_X = 3'd0,
    REG_MAX_X = 3'd1,
    REG_MIN_Y = 3'd2,
    REG_MAX_Y = 3'd3,
    REG_MODE  = 3'd4
  } reg_idx_t;

  localparam logic [1:0] RPT_EVERY   = 2'd0;
  localparam logic [1:0] RPT_ADDED   = 2'd1;
  localparam logic [1:0] RPT_REMOVED = 2'd2;
  localparam logic [1:0] RPT_TALLY   = 2'd3;

  typedef struct packed {
    logic [31:0]          word_old;
    logic [31:0]          word_new;
    logic [ADDR_BITS-1:0] word_address;
    logic                 region_first;
  } in_item_t;

  typedef struct packed {
    logic                  reported;
    logic [2:0]            window_kind;
    logic [ADDR_BITS-1:0]  pair_address;
    logic [31:0]           old_x;
    logic [31:0]           old_y;
    logic [31:0]           new_x;
    logic [31:0]           new_y;
    logic [COUNT_BITS-1:0] differing_windows;
    logic [COUNT_BITS-1:0] new_count;
    logic [COUNT_BITS-1:0] gone_count;
    logic [COUNT_BITS-1:0] changed_count;
  } out_item_t;

  // a <= b for IEEE singles; false when either is NaN, -0 equals +0
  function automatic logic flt_le(input logic [31:0] a, input logic [31:0] b);
    logic a_nan, b_nan, zeros;
    a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
    b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
    zeros = (a[30:0] == '0) && (b[30:0] == '0);
    if (a_nan || b_nan) flt_le = 1'b0;
    else if (zeros) flt_le = 1'b1;
    else if (a[31] != b[31]) flt_le = a[31];
    else if (!a[31]) flt_le = (a[30:0] <= b[30:0]);
    else flt_le = (a[30:0] >= b[30:0]);
  endfunction

  function automatic logic in_range(input logic [31:0] v, input logic [31:0] lo,
                                    input logic [31:0] hi);
    in_range = (v[30:23] != 8'hFF) && flt_le(lo, v) && flt_le(v, hi);
  endfunction

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
    sat_inc = (&c) ? c : c + COUNT_BITS'(1);
  endfunction

endpackage

// ===== rtl/core/float_pair_snapshot_diff_classifier_top.sv =====
// ---------------------------------------------------------------------------
// float_pair_snapshot_diff_classifier_top
// Classifies 8-byte windows of two memory images as coordinate pair changes.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one transfer per aligned 32-bit word pair (old, new, address,
//           region_first). Each accepted word closes a window with the held
//           previous word unless region_first is set or nothing is held.
//   out_* : exactly one result per accepted word, in order.
//   cfg_* : register writes (index 0..4: min_x, max_x, min_y, max_y,
//           report filter); always ready, write only while idle.
// Latency: a result is valid the cycle after its word is accepted.
// Throughput: one word per cycle; the classify logic is one level of float
//   compares and a saturating add between the window registers and the
//   result register.
// Reset: clears held window, counters, registers and the output valid.
// Stall: the result register holds while out_ready is low; in_ready drops
//   only then, and the held window and counters advance only on input
//   transfers.
// ---------------------------------------------------------------------------
`include "float_pair_snapshot_diff_classifier_top_macros.svh"

module float_pair_snapshot_diff_classifier_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  fpsd_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output fpsd_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fpsd_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [31:0]                         cfg_data
);
  import fpsd_pkg::*;

  logic [31:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic [1:0]  mode_r;
  logic [31:0] hold_old_r, hold_new_r;
  logic [ADDR_BITS-1:0] hold_addr_r;
  logic hold_valid_r;
  logic [COUNT_BITS-1:0] diff_r, new_r, gone_r, chg_r;
  logic out_valid_r;
  out_item_t out_r, out_nxt;
  logic [COUNT_BITS-1:0] diff_nxt, new_nxt, gone_nxt, chg_nxt;
  logic in_xfer, window, differs, was, now;

  assign cfg_ready = 1'b1;
  // Accept whenever the result slot is empty or being drained.
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign window  = !in_data.region_first && hold_valid_r;
  assign differs = (hold_old_r != hold_new_r) || (in_data.word_old != in_data.word_new);
  assign was = in_range(hold_old_r, min_x_r, max_x_r) &&
               in_range(in_data.word_old, min_y_r, max_y_r);
  assign now = in_range(hold_new_r, min_x_r, max_x_r) &&
               in_range(in_data.word_new, min_y_r, max_y_r);

  always_comb begin
    diff_nxt = diff_r;
    new_nxt  = new_r;
    gone_nxt = gone_r;
    chg_nxt  = chg_r;
    out_nxt  = '0;
    if (window) begin
      out_nxt.pair_address = hold_addr_r;
      out_nxt.old_x = hold_old_r;
      out_nxt.old_y = in_data.word_old;
      out_nxt.new_x = hold_new_r;
      out_nxt.new_y = in_data.word_new;
      if (differs) begin
        diff_nxt = sat_inc(diff_r);
        if (now && !was) begin
          out_nxt.window_kind = KIND_NEW;
          new_nxt = sat_inc(new_r);
          out_nxt.reported = (mode_r == RPT_EVERY) || (mode_r == RPT_ADDED);
        end else if (was && !now) begin
          out_nxt.window_kind = KIND_GONE;
          gone_nxt = sat_inc(gone_r);
          out_nxt.reported = (mode_r == RPT_EVERY) || (mode_r == RPT_REMOVED);
        end else if (was && now) begin
          out_nxt.window_kind = KIND_CHANGED;
          chg_nxt = sat_inc(chg_r);
          out_nxt.reported = (mode_r == RPT_EVERY);
        end else begin
          out_nxt.window_kind = KIND_DIFF;
        end
      end
    end
    out_nxt.differing_windows = diff_nxt;
    out_nxt.new_count = new_nxt;
    out_nxt.gone_count = gone_nxt;
    out_nxt.changed_count = chg_nxt;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0;
      max_x_r <= '0;
      min_y_r <= '0;
      max_y_r <= '0;
      mode_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_X: min_x_r <= cfg_data;
        REG_MAX_X: max_x_r <= cfg_data;
        REG_MIN_Y: min_y_r <= cfg_data;
        REG_MAX_Y: max_y_r <= cfg_data;
        REG_MODE:  mode_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Window state, counters and result valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_old_r   <= '0;
      hold_new_r   <= '0;
      hold_addr_r  <= '0;
      hold_valid_r <= 1'b0;
      diff_r <= '0;
      new_r  <= '0;
      gone_r <= '0;
      chg_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        hold_old_r   <= in_data.word_old;
        hold_new_r   <= in_data.word_new;
        hold_addr_r  <= in_data.word_address;
        hold_valid_r <= 1'b1;
        diff_r <= diff_nxt;
        new_r  <= new_nxt;
        gone_r <= gone_nxt;
        chg_r  <= chg_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_r <= out_nxt;
    end
  end

  `FPSD_ASSERT_NEXT(a_result_follows, clk, rst_n, in_xfer, out_valid)
  `FPSD_ASSERT_IMPL(a_stall_blocks, clk, rst_n, out_valid && !out_ready, !in_ready)
  `FPSD_ASSERT_IMPL(a_report_has_kind, clk, rst_n, out_valid && out_data.reported,
                    out_data.window_kind != KIND_NONE && out_data.window_kind != KIND_DIFF)
  `FPSD_ASSERT_NEXT(a_diff_monotonic, clk, rst_n, 1'b1, diff_r >= $past(diff_r))

endmodule
